>>> hdl/stq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int SLOTS       = 32;
    localparam int MAX_RESULTS = 32;

    localparam int ADDR_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int FIRED_W    = $clog2(MAX_RESULTS + 1);
    localparam int EXP_W      = 64;
    localparam int HANDLE_W   = 16;
    localparam int INTERVAL_W = 31;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = ((INTERVAL_W + HANDLE_W + 7) / 8) * 8;
    localparam int ENTRY_W    = EXP_W + HANDLE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_FIRED = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // logical slot read: head, head + 1, pos - 1, pos - 2
    typedef enum logic [1:0] {
        RD_HEAD  = 2'd0,
        RD_HEAD1 = 2'd1,
        RD_POS1  = 2'd2,
        RD_POS2  = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_SHIFT = 2'd1,
        WR_NEW   = 2'd2
    } wr_op_t;

    typedef struct packed {
        logic    ld_in;
        logic    tick_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_op_t  wr_op;
        logic    pop;
        logic    out_load;
        kind_t   out_kind;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic count_one;
        logic pos_one;
        logic later_than_new;
        logic expired;
        logic fired_at_limit;
        logic out_free;
    } status_t;

endpackage

>>> hdl/sorted_timer_expiry_queue.sv
// Top level of the sorted one-shot timer queue.
// Add: the sorted insert moves each entry later than the new timer up one slot
//   through the single write port of the store RAM, then writes the new entry.
// Tick: reads the head and pops each expired timer in turn, paced by RAM read latency.
// One item at a time; s_tready is high only while idle. Results wait in one output word.
// Reset (aresetn low, synchronous): tick count, store count and head cleared; no RAM clear.
`timescale 1ns / 1ps

module sorted_timer_expiry_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stq_pkg::S_DATA_W-1:0]       s_tdata,   // interval[30:0], handle[46:31], pad
    input  logic                               s_tuser,   // action[0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stq_pkg::HANDLE_W-1:0]       m_tdata,   // fired_handle[15:0]
    output logic [stq_pkg::KIND_W-1:0]         m_tuser,   // kind[1:0]
    output logic                               m_tlast
);

    import stq_pkg::*;

    cmd_t    cmd;
    status_t status;

    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/stq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/stq_datapath.sv
// Datapath: tick counter, ring-ordered timer store, compares and output register.
`timescale 1ns / 1ps

module stq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  stq_pkg::cmd_t                     cmd,
    output stq_pkg::status_t                  status,
    input  logic [stq_pkg::S_DATA_W-1:0]      s_tdata,   // interval[30:0], handle[46:31], pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stq_pkg::HANDLE_W-1:0]      m_tdata,   // fired_handle[15:0]
    output logic [stq_pkg::KIND_W-1:0]        m_tuser,   // kind[1:0]
    output logic                              m_tlast
);

    import stq_pkg::*;

    logic [EXP_W-1:0]    tick_reg;
    logic [EXP_W-1:0]    exp_reg;
    logic [HANDLE_W-1:0] new_handle_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [FIRED_W-1:0]  fired_reg;
    logic [HANDLE_W-1:0] pending_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_last_reg;

    logic [ENTRY_W-1:0]  rd_data;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    logic [CNT_W-1:0]    rd_offs;
    logic [EXP_W-1:0]    rd_exp;
    logic [ADDR_W-1:0]   head_inc;

    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                               input logic [CNT_W-1:0]  offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
        if (sum >= (CNT_W + 1)'(SLOTS)) begin
            sum = sum - (CNT_W + 1)'(SLOTS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    always_comb begin
        case (cmd.rd_sel)
            RD_HEAD:  rd_offs = '0;
            RD_HEAD1: rd_offs = CNT_W'(1);
            RD_POS1:  rd_offs = pos_reg - CNT_W'(1);
            RD_POS2:  rd_offs = pos_reg - CNT_W'(2);
            default:  rd_offs = '0;
        endcase
    end

    assign rd_addr  = phys(head_reg, rd_offs);
    assign wr_addr  = phys(head_reg, pos_reg);
    assign wr_en    = (cmd.wr_op == WR_SHIFT) || (cmd.wr_op == WR_NEW);
    assign wr_data  = (cmd.wr_op == WR_SHIFT) ? rd_data : {exp_reg, new_handle_reg};
    assign rd_exp   = rd_data[ENTRY_W-1:HANDLE_W];
    assign head_inc = (head_reg == ADDR_W'(SLOTS - 1)) ? '0 : head_reg + ADDR_W'(1);

    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            fired_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.ld_in) begin
                exp_reg        <= tick_reg + EXP_W'(s_tdata[INTERVAL_W-1:0]);
                new_handle_reg <= s_tdata[INTERVAL_W +: HANDLE_W];
                pos_reg        <= count_reg;
                fired_reg      <= '0;
            end
            if (cmd.tick_inc) begin
                tick_reg <= tick_reg + EXP_W'(1);
            end
            if (cmd.wr_op == WR_SHIFT) begin
                pos_reg <= pos_reg - CNT_W'(1);
            end
            if (cmd.wr_op == WR_NEW) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.pop) begin
                head_reg    <= head_inc;
                count_reg   <= count_reg - CNT_W'(1);
                fired_reg   <= fired_reg + FIRED_W'(1);
                pending_reg <= rd_data[HANDLE_W-1:0];
            end
            if (cmd.out_load) begin
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= cmd.out_kind;
                out_handle_reg <= (cmd.out_kind == KIND_FIRED) ? pending_reg : '0;
                out_last_reg   <= cmd.out_last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.full           = (count_reg == CNT_W'(SLOTS));
    assign status.count_zero     = (count_reg == '0);
    assign status.count_one      = (count_reg == CNT_W'(1));
    assign status.pos_one        = (pos_reg == CNT_W'(1));
    assign status.later_than_new = (rd_exp > exp_reg);
    assign status.expired        = (rd_exp < tick_reg);
    assign status.fired_at_limit = (fired_reg == FIRED_W'(MAX_RESULTS - 1));
    assign status.out_free       = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_handle_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("timer count above store size");

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_op == WR_NEW |-> !status.full)
        else $error("insert into full store");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !status.count_zero && cmd.wr_op == WR_NONE)
        else $error("pop from empty store or during insert");

    a_out_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output word overwritten before taken");
`endif

endmodule

>>> hdl/stq_ctrl.sv
// Controller: sequences sorted insert and expiry sweep, drives datapath commands.
`timescale 1ns / 1ps

module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tuser,    // action[0]
    output logic               s_tready,
    input  stq_pkg::status_t   status,
    output stq_pkg::cmd_t      cmd
);

    import stq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADD_SHIFT,
        ST_ADD_PLACE,
        ST_ADD_DONE,
        ST_TICK,
        ST_TICK_HEAD,
        ST_TICK_NEXT,
        ST_TICK_LAST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_HEAD;
        cmd.wr_op    = WR_NONE;
        cmd.out_kind = KIND_ADDED;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.ld_in = 1'b1;
                    if (s_tuser) begin
                        cmd.tick_inc = 1'b1;
                        state_next   = ST_TICK;
                    end else begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                if (status.full) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_FULL;
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (status.count_zero) begin
                    cmd.wr_op  = WR_NEW;
                    state_next = ST_ADD_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS1;
                    state_next = ST_ADD_SHIFT;
                end
            end
            ST_ADD_SHIFT: begin
                if (status.later_than_new) begin
                    cmd.wr_op = WR_SHIFT;
                    if (status.pos_one) begin
                        state_next = ST_ADD_PLACE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS2;
                    end
                end else begin
                    cmd.wr_op  = WR_NEW;
                    state_next = ST_ADD_DONE;
                end
            end
            ST_ADD_PLACE: begin
                cmd.wr_op  = WR_NEW;
                state_next = ST_ADD_DONE;
            end
            ST_ADD_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ADDED;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (status.count_zero) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_NONE;
                        cmd.out_last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_HEAD;
                    state_next = ST_TICK_HEAD;
                end
            end
            ST_TICK_HEAD: begin
                if (status.expired) begin
                    cmd.pop = 1'b1;
                    if (status.count_one || status.fired_at_limit) begin
                        state_next = ST_TICK_LAST;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD1;
                        state_next = ST_TICK_NEXT;
                    end
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_NONE;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK_NEXT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_FIRED;
                    cmd.out_last = !status.expired;
                    if (status.expired) begin
                        cmd.pop = 1'b1;
                        if (status.count_one || status.fired_at_limit) begin
                            state_next = ST_TICK_LAST;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD1;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TICK_LAST: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_FIRED;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> state_reg == ST_IDLE)
        else $error("ready raised outside idle");

    a_single_result_add: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && (cmd.out_kind == KIND_ADDED || cmd.out_kind == KIND_FULL)
        |-> cmd.out_last)
        else $error("add result without last");

    a_write_xor_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pop && cmd.wr_op != WR_NONE))
        else $error("store written while popping");
`endif

endmodule

>>> test/stq_expiry_check.sv
// Checker for the timer queue: tracks the stored timers and compares every result word.
`timescale 1ns / 1ps

module stq_expiry_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [stq_pkg::S_DATA_W-1:0]   s_tdata,    // interval[30:0], handle[46:31], pad
    input  logic                           s_tuser,    // action[0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [stq_pkg::HANDLE_W-1:0]   m_tdata,    // fired_handle[15:0]
    input  logic [stq_pkg::KIND_W-1:0]     m_tuser,    // kind[1:0]
    input  logic                           m_tlast,
    output int                             mismatches,
    output int                             words_owed
);

    import stq_pkg::*;

    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } result_word_t;

    result_word_t        owed_words[$];
    logic [EXP_W-1:0]    ticks_now;
    logic [EXP_W-1:0]    timer_expiry[SLOTS];
    logic [HANDLE_W-1:0] timer_handle[SLOTS];
    int                  timers_held;

    initial begin
        mismatches = 0;
        words_owed = 0;
        ticks_now  = '0;
        timers_held = 0;
    end

    function automatic result_word_t make_word(kind_t k, logic [HANDLE_W-1:0] h, logic l);
        result_word_t w;
        w.kind   = k;
        w.handle = h;
        w.last   = l;
        return w;
    endfunction

    // Sorted insert on add; advance and sweep expired timers on tick.
    function automatic void apply_item(logic act, logic [INTERVAL_W-1:0] iv,
                                       logic [HANDLE_W-1:0] h);
        logic [EXP_W-1:0] due;
        int               pos;
        int               fired;
        if (!act) begin
            if (timers_held >= SLOTS) begin
                owed_words.push_back(make_word(KIND_FULL, '0, 1'b1));
            end else begin
                due = ticks_now + EXP_W'(iv);
                pos = 0;
                while (pos < timers_held && timer_expiry[pos] <= due) pos++;
                for (int i = timers_held; i > pos; i--) begin
                    timer_expiry[i] = timer_expiry[i-1];
                    timer_handle[i] = timer_handle[i-1];
                end
                timer_expiry[pos] = due;
                timer_handle[pos] = h;
                timers_held++;
                owed_words.push_back(make_word(KIND_ADDED, '0, 1'b1));
            end
        end else begin
            ticks_now = ticks_now + 1'b1;
            fired = 0;
            while (fired < timers_held && fired < MAX_RESULTS &&
                   timer_expiry[fired] < ticks_now) begin
                owed_words.push_back(make_word(KIND_FIRED, timer_handle[fired], 1'b0));
                fired++;
            end
            if (fired == 0) begin
                owed_words.push_back(make_word(KIND_NONE, '0, 1'b1));
            end else begin
                owed_words[$].last = 1'b1;
                for (int i = fired; i < timers_held; i++) begin
                    timer_expiry[i-fired] = timer_expiry[i];
                    timer_handle[i-fired] = timer_handle[i];
                end
                timers_held -= fired;
            end
        end
    endfunction

    always @(posedge aclk) begin
        result_word_t want;
        if (!aresetn) begin
            owed_words.delete();
            ticks_now   = '0;
            timers_held = 0;
        end else begin
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata[INTERVAL_W-1:0],
                           s_tdata[INTERVAL_W +: HANDLE_W]);
            if (m_tvalid && m_tready) begin
                if (owed_words.size() == 0) begin
                    $display("%0t: unexpected word kind %0d handle %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = owed_words.pop_front();
                    if (m_tuser !== want.kind) begin
                        $display("%0t: kind expected %0d got %0d", $time, want.kind, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata !== want.handle) begin
                        $display("%0t: handle expected %h got %h", $time, want.handle, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        words_owed = owed_words.size();
    end

endmodule

>>> test/tb_sorted_timer_expiry_queue.sv
// Testbench top for the timer queue: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_sorted_timer_expiry_queue;
    import stq_pkg::*;

    localparam int RANDOM_ITEMS = 470;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [HANDLE_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    int                    mismatches;
    int                    words_owed;
    int                    send_idle = 0;
    int                    recv_stall = 0;
    int                    cycle_n = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sorted_timer_expiry_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    stq_expiry_check i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .words_owed (words_owed)
    );

    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_stall);

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called just after a rising edge; returns at the edge that takes the word.
    task automatic offer_word(input logic act, input logic [INTERVAL_W-1:0] iv,
                              input logic [HANDLE_W-1:0] h);
        if ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_DATA_W - INTERVAL_W - HANDLE_W){1'b0}}, h, iv};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic add_timer(input logic [INTERVAL_W-1:0] iv, input logic [HANDLE_W-1:0] h);
        offer_word(1'b0, iv, h);
    endtask

    task automatic tick_once();
        offer_word(1'b1, INTERVAL_W'($urandom), HANDLE_W'($urandom));
    endtask

    task automatic random_item();
        int                    pick;
        logic [INTERVAL_W-1:0] iv;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            tick_once();
        end else begin
            if (pick < 46)
                iv = INTERVAL_W'($urandom);
            else if (pick < 80)
                iv = INTERVAL_W'($urandom_range(0, 4));
            else
                iv = INTERVAL_W'($urandom_range(0, 40));
            add_timer(iv, HANDLE_W'($urandom));
        end
    endtask

    initial begin
        int done_n;
        int phase;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty tick, equal expiries, extremes of interval and handle
        tick_once();
        add_timer('0, 16'h0000);
        add_timer('0, 16'hFFFF);
        add_timer(31'd2, 16'h1234);
        add_timer({INTERVAL_W{1'b1}}, 16'hA5A5);
        add_timer(31'd1, 16'h5A5A);
        tick_once();
        tick_once();
        tick_once();
        tick_once();
        add_timer(31'd3, 16'h0001);
        add_timer(31'd1, 16'h0002);
        add_timer(31'd3, 16'h0003);
        add_timer(31'd2, 16'h0004);
        add_timer(31'd1, 16'h0005);
        repeat (5) tick_once();

        // random: mostly short intervals, with fill bursts that overflow the store
        done_n = 0;
        while (done_n < RANDOM_ITEMS) begin
            phase = (done_n / 40) % 4;
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 66; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 66; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            if (done_n % 110 == 10) begin
                repeat (36) add_timer(INTERVAL_W'($urandom_range(0, 6)), HANDLE_W'($urandom));
                done_n += 36;
            end else begin
                random_item();
                done_n++;
            end
        end
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (words_owed != 0);
        repeat (60) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
